// ===== rtl/core/wh2d_pkg.sv =====
package wh2d_pkg;

    localparam int DEF_MAX_BINS_X = 64;
    localparam int DEF_MAX_BINS_Y = 64;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_X_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = 3'd7;

    localparam logic [31:0] RST_X_LOW   = 32'd0;
    localparam logic [31:0] RST_X_HIGH  = 32'd4194304;
    localparam logic [31:0] RST_Y_LOW   = 32'd0;
    localparam logic [31:0] RST_Y_HIGH  = 32'd4194304;
    localparam logic [6:0]  RST_BINS    = 7'd64;
    localparam logic [31:0] RST_SCALE   = 32'd65536;

    localparam logic [47:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] S48_MIN = 48'h8000_0000_0000;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_W,
        S_INDEX,
        S_READ,
        S_WRITE
    } wh2d_state_t;

    typedef struct packed {
        logic clear;
        logic rd;
        logic wr;
    } store_ctl_t;

    // signed 48-bit accumulate of a signed 32-bit addend, clipped at the limits
    function automatic logic [47:0] sat_add_s48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {a[47], a} + {{17{b[31]}}, b};
        if (s[48] != s[47])
        begin
            return s[48] ? S48_MIN : S48_MAX;
        end
        return s[47:0];
    endfunction

endpackage

// ===== rtl/core/wh2d_store.sv =====
module wh2d_store #(
    parameter int DEPTH = wh2d_pkg::DEF_MAX_BINS_X * wh2d_pkg::DEF_MAX_BINS_Y
) (
    input  logic                  clk,
    input  wh2d_pkg::store_ctl_t  ctl,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [31:0]           weight,
    input  logic [47:0]           w2,
    output logic [47:0]           sum_out,
    output logic [47:0]           sq_out
);
    import wh2d_pkg::*;

    logic [95:0] mem [DEPTH];
    logic [95:0] rd_data_reg;
    logic [48:0] sq_wide;

    // bin sum in the upper half, squared sum in the lower half
    always_comb
    begin
        sum_out = sat_add_s48(rd_data_reg[95:48], weight);
        sq_wide = {1'b0, rd_data_reg[47:0]} + {1'b0, w2};
        sq_out  = sq_wide[48] ? '1 : sq_wide[47:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            mem[addr] <= '0;
        end
        else if (ctl.wr)
        begin
            mem[addr] <= {sum_out, sq_out};
        end
        if (ctl.rd)
        begin
            rd_data_reg <= mem[addr];
        end
    end

endmodule

// ===== rtl/core/weighted_2d_histogram_fill.sv =====
// Two-dimensional weighted histogram over a bin store of MAX_BINS_X*MAX_BINS_Y entries.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, cfg_ready is always high;
// write registers only while busy is low and no result is pending.
// Items: a transaction is taken at a clock edge with start high and busy low.
// action 0 fills a point with a weight, action 1 reads the bin at read_bin.
// Results: done is high for one cycle with in_range, bin_index, bin_sum,
// bin_sum_sq and entry_total valid in that cycle; the receiver cannot stall,
// so nothing is held back.
// Timing: a fill steps through S_MUL_X, S_MUL_Y, S_MUL_W, S_INDEX, S_READ and S_WRITE
// before done, a read through S_READ and S_WRITE only. busy falls in the done cycle,
// so the next transaction can be taken there, and none is taken before it. The fill
// time is set by one shared 32x32 multiplier used in turn for the x bin, the y bin and
// the squared weight, then the bin index, and the read and write-back of the bin memory.
// Reset: configuration returns to its defaults, the entry total clears, and
// the store is cleared one entry per cycle, all MAX_BINS_X*MAX_BINS_Y entries
// (4096 at the defaults), with busy high; configuration writes are taken then.
module weighted_2d_histogram_fill #(
    parameter int MAX_BINS_X = wh2d_pkg::DEF_MAX_BINS_X,
    parameter int MAX_BINS_Y = wh2d_pkg::DEF_MAX_BINS_Y
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wh2d_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic signed [31:0]              x_value,
    input  logic signed [31:0]              y_value,
    input  logic signed [31:0]              weight,
    input  logic [11:0]                     read_bin,
    output logic                            done,
    output logic                            in_range,
    output logic [11:0]                     bin_index,
    output logic signed [47:0]              bin_sum,
    output logic [47:0]                     bin_sum_sq,
    output logic signed [47:0]              entry_total
);
    import wh2d_pkg::*;

    localparam int DEPTH  = MAX_BINS_X * MAX_BINS_Y;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [6:0] eff_bins(input logic [6:0] n, input int maxn);
        if (n == 7'd0)
        begin
            return 7'd1;
        end
        if ({25'b0, n} > 32'(maxn))
        begin
            return 7'(maxn);
        end
        return n;
    endfunction

    function automatic logic [6:0] clamp_bin(input logic [31:0] b, input logic [6:0] nb);
        logic [6:0] top;
        top = nb - 7'd1;
        if (b > {25'b0, top})
        begin
            return top;
        end
        return b[6:0];
    endfunction

    wh2d_state_t state_reg, state_next;

    logic [31:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic [31:0] x_scale_reg, y_scale_reg;
    logic [6:0]  bins_x_reg, bins_y_reg;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [47:0]       total_reg;
    logic              done_reg;

    logic              is_fill_reg, in_store_reg, inx_reg, iny_reg;
    logic [31:0]       dx_reg, dy_reg, wmag_reg, weight_reg;
    logic [47:0]       w2_reg;
    logic [63:0]       prod_reg;
    logic [6:0]        bx_reg, by_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [11:0]       idx_reg, read_bin_reg;

    logic              in_range_reg;
    logic [11:0]       bin_index_reg;
    logic [47:0]       bin_sum_reg, bin_sum_sq_reg, entry_total_reg;

    logic              accept;
    logic [6:0]        nbx, nby;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       product;
    logic [32:0]       dx_wide, dy_wide;
    logic              inx, iny;
    logic [13:0]       idx_flat;
    logic [ADDR_W+13:0] idx_ext;
    logic [ADDR_W+11:0] rb_ext;
    logic              hit, bin_ok;
    logic [47:0]       total_next;
    store_ctl_t        ctl;
    logic [ADDR_W-1:0] st_addr;
    logic [47:0]       st_sum, st_sq;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;

    assign nbx = eff_bins(bins_x_reg, MAX_BINS_X);
    assign nby = eff_bins(bins_y_reg, MAX_BINS_Y);

    assign dx_wide = {x_value[31], x_value} - {x_low_reg[31], x_low_reg};
    assign dy_wide = {y_value[31], y_value} - {y_low_reg[31], y_low_reg};
    assign inx = ($signed(x_value) >= $signed(x_low_reg)) &&
                 ($signed(x_value) <  $signed(x_high_reg));
    assign iny = ($signed(y_value) >= $signed(y_low_reg)) &&
                 ($signed(y_value) <  $signed(y_high_reg));

    assign idx_flat = ({7'b0, by_reg} * {7'b0, nbx}) + {7'b0, bx_reg};
    assign idx_ext  = {{ADDR_W{1'b0}}, idx_flat};
    assign rb_ext   = {{ADDR_W{1'b0}}, read_bin};

    assign product = {32'b0, mul_a} * {32'b0, mul_b};

    assign hit        = inx_reg && iny_reg;
    assign bin_ok     = is_fill_reg ? hit : in_store_reg;
    assign total_next = is_fill_reg ? sat_add_s48(total_reg, weight_reg) : total_reg;
    assign st_addr    = (state_reg == S_CLEAR) ? clr_cnt_reg : addr_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        mul_a      = dx_reg;
        mul_b      = x_scale_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = action ? S_READ : S_MUL_X;
                end
            end
            S_MUL_X:
            begin
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                mul_a      = dy_reg;
                mul_b      = y_scale_reg;
                state_next = S_MUL_W;
            end
            S_MUL_W:
            begin
                mul_a      = wmag_reg;
                mul_b      = wmag_reg;
                state_next = S_INDEX;
            end
            S_INDEX:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                ctl.rd     = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                ctl.wr     = is_fill_reg && hit;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            total_reg   <= '0;
            done_reg    <= 1'b0;
            x_low_reg   <= RST_X_LOW;
            x_high_reg  <= RST_X_HIGH;
            y_low_reg   <= RST_Y_LOW;
            y_high_reg  <= RST_Y_HIGH;
            bins_x_reg  <= RST_BINS;
            bins_y_reg  <= RST_BINS;
            x_scale_reg <= RST_SCALE;
            y_scale_reg <= RST_SCALE;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_WRITE);
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == S_WRITE)
            begin
                total_reg <= total_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_X_LOW:   x_low_reg   <= cfg_data;
                    REG_X_HIGH:  x_high_reg  <= cfg_data;
                    REG_Y_LOW:   y_low_reg   <= cfg_data;
                    REG_Y_HIGH:  y_high_reg  <= cfg_data;
                    REG_BINS_X:  bins_x_reg  <= cfg_data[6:0];
                    REG_BINS_Y:  bins_y_reg  <= cfg_data[6:0];
                    REG_X_SCALE: x_scale_reg <= cfg_data;
                    REG_Y_SCALE: y_scale_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_fill_reg  <= !action;
            read_bin_reg <= read_bin;
            in_store_reg <= (rb_ext < (ADDR_W + 12)'(DEPTH));
            inx_reg      <= inx;
            iny_reg      <= iny;
            dx_reg       <= dx_wide[31:0];
            dy_reg       <= dy_wide[31:0];
            wmag_reg     <= weight[31] ? (~weight + 32'd1) : weight;
            // reads pass through the store adder with a zero addend
            weight_reg   <= action ? 32'd0 : weight;
            w2_reg       <= '0;
            addr_reg     <= rb_ext[ADDR_W-1:0];
        end
        case (state_reg)
            S_MUL_X:
            begin
                prod_reg <= product;
            end
            S_MUL_Y:
            begin
                prod_reg <= product;
                bx_reg   <= clamp_bin(prod_reg[63:32], nbx);
            end
            S_MUL_W:
            begin
                prod_reg <= product;
                by_reg   <= clamp_bin(prod_reg[63:32], nby);
            end
            S_INDEX:
            begin
                w2_reg   <= prod_reg[63:16];
                addr_reg <= idx_ext[ADDR_W-1:0];
                idx_reg  <= idx_flat[11:0];
            end
            S_WRITE:
            begin
                in_range_reg    <= is_fill_reg ? hit : 1'b1;
                bin_index_reg   <= is_fill_reg ? (hit ? idx_reg : 12'd0) : read_bin_reg;
                bin_sum_reg     <= bin_ok ? st_sum : 48'd0;
                bin_sum_sq_reg  <= bin_ok ? st_sq : 48'd0;
                entry_total_reg <= total_next;
            end
            default:
            begin
            end
        endcase
    end

    wh2d_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .clk     (clk),
        .ctl     (ctl),
        .addr    (st_addr),
        .weight  (weight_reg),
        .w2      (w2_reg),
        .sum_out (st_sum),
        .sq_out  (st_sq)
    );

    assign done        = done_reg;
    assign in_range    = in_range_reg;
    assign bin_index   = bin_index_reg;
    assign bin_sum     = bin_sum_reg;
    assign bin_sum_sq  = bin_sum_sq_reg;
    assign entry_total = entry_total_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while an item is still in flight");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> (bin_sum == 48'd0 && bin_sum_sq == 48'd0 &&
                                 bin_index == 12'd0))
        else $error("out of range fill reported bin contents");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr || ctl.rd) |-> (state_reg == S_READ || state_reg == S_WRITE))
        else $error("store access outside the read-modify-write window");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import wh2d_pkg::*;

    localparam bit ACT_FILL = 1'b0;
    localparam bit ACT_READ = 1'b1;
    localparam int STORE_DEPTH = DEF_MAX_BINS_X * DEF_MAX_BINS_Y;
    localparam longint SUM_TOP = 64'sh7FFF_FFFF_FFFF;
    localparam longint SUM_BOTTOM = -SUM_TOP - 1;
    localparam longint unsigned SQ_TOP = 64'hFFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEMS_PER_SETUP = 216;
    localparam int CLIP_FILLS = 8;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic        in_range;
        logic [11:0] bin_index;
        logic [47:0] bin_sum;
        logic [47:0] bin_sum_sq;
        logic [47:0] entry_total;
    } histo_result_t;

    typedef struct {
        bit                 act;
        bit signed [31:0]   xv;
        bit signed [31:0]   yv;
        bit signed [31:0]   w;
        bit [11:0]          rb;
        bit                 typed;
        histo_result_t      want;
    } probe_row_t;

    typedef struct {
        bit signed [31:0] x_low;
        bit signed [31:0] x_high;
        bit signed [31:0] y_low;
        bit signed [31:0] y_high;
        bit [6:0]         bins_x;
        bit [6:0]         bins_y;
        bit [31:0]        x_scale;
        bit [31:0]        y_scale;
    } hist_setup_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [31:0]            cfg_data = '0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   action = 1'b0;
    logic signed [31:0]     x_value = '0;
    logic signed [31:0]     y_value = '0;
    logic signed [31:0]     weight = '0;
    logic [11:0]            read_bin = '0;
    logic                   done;
    logic                   in_range;
    logic [11:0]            bin_index;
    logic signed [47:0]     bin_sum;
    logic [47:0]            bin_sum_sq;
    logic signed [47:0]     entry_total;

    // predictor copy of the registers and the bin store
    bit signed [31:0]   hist_x_low = RST_X_LOW;
    bit signed [31:0]   hist_x_high = RST_X_HIGH;
    bit signed [31:0]   hist_y_low = RST_Y_LOW;
    bit signed [31:0]   hist_y_high = RST_Y_HIGH;
    bit [6:0]           hist_bins_x = RST_BINS;
    bit [6:0]           hist_bins_y = RST_BINS;
    bit [31:0]          hist_x_scale = RST_SCALE;
    bit [31:0]          hist_y_scale = RST_SCALE;
    bit signed [47:0]   weight_sums [0:STORE_DEPTH-1];
    bit [47:0]          square_sums [0:STORE_DEPTH-1];
    bit signed [47:0]   weight_total = '0;

    histo_result_t      pending_results[$];
    histo_result_t      arrived_want;
    probe_row_t         probe_rows[$];
    bit                 idle_on = 1'b1;
    bit [11:0]          last_landed = '0;
    int                 mismatch_count = 0;
    int                 fills_sent = 0;
    int                 fills_landed = 0;
    int                 reads_sent = 0;
    int                 setups_applied = 0;
    int                 clips_seen = 0;
    int                 cycle_count = 0;

    weighted_2d_histogram_fill DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .action(action),
        .x_value(x_value),
        .y_value(y_value),
        .weight(weight),
        .read_bin(read_bin),
        .done(done),
        .in_range(in_range),
        .bin_index(bin_index),
        .bin_sum(bin_sum),
        .bin_sum_sq(bin_sum_sq),
        .entry_total(entry_total)
    );

    always #6 clk = ~clk;

    function automatic bit signed [47:0] clip_add48(bit signed [47:0] a, bit signed [31:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > SUM_TOP)
        begin
            s = SUM_TOP;
        end
        else if (s < SUM_BOTTOM)
        begin
            s = SUM_BOTTOM;
        end
        return s[47:0];
    endfunction

    function automatic int unsigned bins_in_use(bit [6:0] n, int unsigned top);
        if (n == 0)
        begin
            return 1;
        end
        return (n > top) ? top : n;
    endfunction

    function automatic bit locate_axis(bit signed [31:0] v, bit signed [31:0] lo,
                                       bit signed [31:0] hi, bit [31:0] scale,
                                       int unsigned nbins, output int unsigned bin);
        longint unsigned d;
        longint unsigned b;
        bin = 0;
        if (!(v >= lo && v < hi))
        begin
            return 1'b0;
        end
        d = longint'(v) - longint'(lo);
        b = (d * scale) >> 32;
        if (b > nbins - 1)
        begin
            b = nbins - 1;
        end
        bin = 32'(b);
        return 1'b1;
    endfunction

    // applies one transaction to the predictor store and returns its result
    function automatic histo_result_t predict_histogram(bit act, bit signed [31:0] xv,
                                                        bit signed [31:0] yv,
                                                        bit signed [31:0] w, bit [11:0] rb);
        histo_result_t r;
        int unsigned nbx;
        int unsigned nby;
        int unsigned bx;
        int unsigned by;
        int unsigned idx;
        longint sw;
        longint unsigned mag;
        longint unsigned sq;
        r = '0;
        nbx = bins_in_use(hist_bins_x, DEF_MAX_BINS_X);
        nby = bins_in_use(hist_bins_y, DEF_MAX_BINS_Y);
        if (act == ACT_FILL)
        begin
            if (locate_axis(xv, hist_x_low, hist_x_high, hist_x_scale, nbx, bx) &&
                locate_axis(yv, hist_y_low, hist_y_high, hist_y_scale, nby, by))
            begin
                sw = w;
                if (sw < 0)
                begin
                    sw = -sw;
                end
                mag = sw;
                idx = by * nbx + bx;
                weight_sums[idx] = clip_add48(weight_sums[idx], w);
                sq = square_sums[idx];
                sq = sq + ((mag * mag) >> 16);
                if (sq > SQ_TOP)
                begin
                    sq = SQ_TOP;
                end
                square_sums[idx] = sq[47:0];
                r.in_range = 1'b1;
                r.bin_index = idx[11:0];
                r.bin_sum = weight_sums[idx];
                r.bin_sum_sq = square_sums[idx];
            end
            weight_total = clip_add48(weight_total, w);
        end
        else
        begin
            r.in_range = 1'b1;
            r.bin_index = rb;
            r.bin_sum = weight_sums[rb];
            r.bin_sum_sq = square_sums[rb];
        end
        r.entry_total = weight_total;
        return r;
    endfunction

    function automatic void check_field(string label, logic [47:0] want_v, logic [47:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    function automatic void probe(bit act, bit signed [31:0] xv, bit signed [31:0] yv,
                                  bit signed [31:0] w, bit [11:0] rb, bit typed,
                                  histo_result_t want);
        probe_row_t row;
        row.act = act;
        row.xv = xv;
        row.yv = yv;
        row.w = w;
        row.rb = rb;
        row.typed = typed;
        row.want = want;
        probe_rows.push_back(row);
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned roll;
        if (!idle_on)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic bit signed [31:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            3, 4, 5: return $urandom_range(0, 32'h3FFFF) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    // coordinate inside [lo, hi) when that interval is not empty
    function automatic bit signed [31:0] pick_coord(bit signed [31:0] lo, bit signed [31:0] hi);
        longint unsigned span;
        longint unsigned offs;
        longint c;
        if (hi <= lo)
        begin
            return $urandom;
        end
        span = longint'(hi) - longint'(lo);
        case ($urandom_range(0, 7))
            0: offs = 0;
            1: offs = span - 1;
            default: offs = {$urandom, $urandom} % span;
        endcase
        c = longint'(lo) + longint'(offs);
        return c[31:0];
    endfunction

    function automatic hist_setup_t plan_setup(int k);
        hist_setup_t s;
        s.x_low = RST_X_LOW;
        s.x_high = RST_X_HIGH;
        s.y_low = RST_Y_LOW;
        s.y_high = RST_Y_HIGH;
        s.bins_x = RST_BINS;
        s.bins_y = RST_BINS;
        s.x_scale = RST_SCALE;
        s.y_scale = RST_SCALE;
        case (k)
            0:
            begin
                // whole coordinate range below the top value, 64 bins per axis
                s.x_low = 32'sh8000_0000;
                s.x_high = 32'sh7FFF_FFFF;
                s.y_low = 32'sh8000_0000;
                s.y_high = 32'sh7FFF_FFFF;
                s.x_scale = 32'd64;
                s.y_scale = 32'd64;
            end
            1:
            begin
                s.x_low = 32'shFFF8_0000;
                s.x_high = 32'sh0008_0000;
                s.bins_x = 7'd16;
                s.y_low = 32'shFFFC_0000;
                s.y_high = 32'sh0004_0000;
                s.bins_y = 7'd40;
                s.y_scale = 32'h0005_0000;
            end
            2:
            begin
                s.x_high = 32'sh0001_0000;
                s.y_high = 32'sh0001_0000;
                s.bins_x = 7'd1;
                s.bins_y = 7'd1;
                s.x_scale = 32'hFFFF_FFFF;
                s.y_scale = 32'hFFFF_FFFF;
            end
            3:
            begin
                // zero bin count, oversized bin count, zero scale
                s.x_low = 32'shFFFE_0000;
                s.x_high = 32'sh0002_0000;
                s.y_high = 32'sh0002_0000;
                s.bins_x = 7'd0;
                s.bins_y = 7'd127;
                s.x_scale = 32'd0;
                s.y_scale = 32'h0020_0000;
            end
            4:
            begin
                s.x_low = 32'sh0005_0000;
                s.x_high = 32'sh0005_0000;
            end
            5:
            begin
                s.x_low = 32'sh7FFF_FFFF;
                s.x_high = 32'sh8000_0000;
                s.y_low = 32'sh7FFF_FFFF;
                s.y_high = 32'sh8000_0000;
            end
            6:
            begin
                s.x_high = 32'sh0000_4000;
                s.x_scale = 32'h0100_0000;
                s.y_low = 32'shFFFF_0000;
                s.y_high = 32'sh0001_0000;
                s.bins_y = 7'd1;
                s.y_scale = 32'h0000_8000;
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_X_LOW: hist_x_low = data;
            REG_X_HIGH: hist_x_high = data;
            REG_Y_LOW: hist_y_low = data;
            REG_Y_HIGH: hist_y_high = data;
            REG_BINS_X: hist_bins_x = data[6:0];
            REG_BINS_Y: hist_bins_y = data[6:0];
            REG_X_SCALE: hist_x_scale = data;
            REG_Y_SCALE: hist_y_scale = data;
            default: ;
        endcase
    endtask

    task automatic apply_setup(input hist_setup_t s);
        write_register(REG_X_LOW, s.x_low);
        write_register(REG_X_HIGH, s.x_high);
        write_register(REG_Y_LOW, s.y_low);
        write_register(REG_Y_HIGH, s.y_high);
        write_register(REG_BINS_X, 32'(s.bins_x));
        write_register(REG_BINS_Y, 32'(s.bins_y));
        write_register(REG_X_SCALE, s.x_scale);
        write_register(REG_Y_SCALE, s.y_scale);
        cfg_valid <= 1'b0;
        setups_applied++;
    endtask

    task automatic send_item(input bit act, input bit signed [31:0] xv, input bit signed [31:0] yv,
                             input bit signed [31:0] w, input bit [11:0] rb,
                             input bit use_given, input histo_result_t given);
        histo_result_t predicted;
        int unsigned gap;
        start <= 1'b1;
        action <= act;
        x_value <= xv;
        y_value <= yv;
        weight <= w;
        read_bin <= rb;
        do @(posedge clk); while (busy);
        predicted = predict_histogram(act, xv, yv, w, rb);
        pending_results.push_back(use_given ? given : predicted);
        if (act == ACT_FILL)
        begin
            fills_sent++;
            if (predicted.in_range)
            begin
                fills_landed++;
                last_landed = predicted.bin_index;
            end
        end
        else
        begin
            reads_sent++;
        end
        gap = draw_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int unsigned roll;
        bit signed [31:0] xv;
        bit signed [31:0] yv;
        bit [11:0] rb;
        for (int i = 0; i < count; i++)
        begin
            // alternate stretches with and without idle cycles
            if (i % 32 == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            rb = 12'($urandom_range(0, STORE_DEPTH - 1));
            if (roll < 65)
            begin
                xv = pick_coord(hist_x_low, hist_x_high);
                yv = pick_coord(hist_y_low, hist_y_high);
                send_item(ACT_FILL, xv, yv, pick_weight(), rb, 1'b0, '0);
            end
            else if (roll < 80)
            begin
                send_item(ACT_FILL, $urandom, $urandom, pick_weight(), rb, 1'b0, '0);
            end
            else
            begin
                if ($urandom_range(0, 1))
                begin
                    rb = last_landed;
                end
                send_item(ACT_READ, $urandom, $urandom, $urandom, rb, 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: index %h sum %h sq %h total %h",
                         $time, bin_index, bin_sum, bin_sum_sq, entry_total);
                mismatch_count++;
            end
            else
            begin
                arrived_want = pending_results.pop_front();
                check_field("in_range", arrived_want.in_range, in_range);
                check_field("bin_index", arrived_want.bin_index, bin_index);
                check_field("bin_sum", arrived_want.bin_sum, bin_sum);
                check_field("bin_sum_sq", arrived_want.bin_sum_sq, bin_sum_sq);
                check_field("entry_total", arrived_want.entry_total, entry_total);
                if (bin_sum == S48_MAX || bin_sum == S48_MIN || bin_sum_sq == SQ_TOP[47:0] ||
                    entry_total == S48_MAX || entry_total == S48_MIN)
                begin
                    clips_seen++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        foreach (weight_sums[k])
        begin
            weight_sums[k] = '0;
            square_sums[k] = '0;
        end

        // directed rows at the reset settings: 64x64 bins of one unit over [0, 64)
        probe(ACT_READ, 0, 0, 0, 12'd0, 1'b1,
              histo_result_t'{1'b1, 12'd0, 48'h0, 48'h0, 48'h0});
        probe(ACT_READ, 0, 0, 0, 12'd4095, 1'b1,
              histo_result_t'{1'b1, 12'd4095, 48'h0, 48'h0, 48'h0});
        probe(ACT_FILL, 32'sh0, 32'sh0, 32'sh0001_0000, 12'd0, 1'b1,
              histo_result_t'{1'b1, 12'd0, 48'h1_0000, 48'h1_0000, 48'h1_0000});
        probe(ACT_FILL, 32'sh003F_FFFF, 32'sh003F_FFFF, 32'shFFFF_0000, 12'd0, 1'b1,
              histo_result_t'{1'b1, 12'd4095, 48'hFFFF_FFFF_0000, 48'h1_0000, 48'h0});
        // on the exclusive high edge, then just below the low edge
        probe(ACT_FILL, 32'sh0040_0000, 32'sh0, 32'sh0002_0000, 12'd0, 1'b1,
              histo_result_t'{1'b0, 12'd0, 48'h0, 48'h0, 48'h2_0000});
        probe(ACT_FILL, 32'shFFFF_FFFF, 32'sh0, 32'sh7FFF_FFFF, 12'd0, 1'b1,
              histo_result_t'{1'b0, 12'd0, 48'h0, 48'h0, 48'h8001_FFFF});
        probe(ACT_FILL, 32'sh0001_0000, 32'sh0002_0000, 32'sh8000_0000, 12'd0, 1'b1,
              histo_result_t'{1'b1, 12'd129, 48'hFFFF_8000_0000, 48'h4000_0000_0000,
                              48'h1_FFFF});
        probe(ACT_FILL, 32'sh0001_0000, 32'sh0002_0000, 32'sh8000_0000, 12'd0, 1'b1,
              histo_result_t'{1'b1, 12'd129, 48'hFFFF_0000_0000, 48'h8000_0000_0000,
                              48'hFFFF_8001_FFFF});
        // squared sum runs into its limit
        probe(ACT_FILL, 32'sh0001_0000, 32'sh0002_0000, 32'sh8000_0000, 12'd0, 1'b0, '0);
        probe(ACT_FILL, 32'sh0001_0000, 32'sh0002_0000, 32'sh8000_0000, 12'd0, 1'b0, '0);
        probe(ACT_FILL, 32'sh0001_0000, 32'sh0002_0000, 32'sh7FFF_FFFF, 12'd0, 1'b0, '0);
        probe(ACT_READ, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 12'd129, 1'b0, '0);
        probe(ACT_FILL, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 12'hFFF, 1'b0, '0);
        probe(ACT_FILL, 32'sh03FF_FFFF, 32'sh0, 32'shFFFF_FFFF, 12'd0, 1'b0, '0);
        probe(ACT_FILL, 32'sh0, 32'sh03FF_FFFF, 32'sh1234_5678, 12'd0, 1'b0, '0);
        probe(ACT_READ, 0, 0, 0, 12'd63, 1'b0, '0);
        probe(ACT_READ, 0, 0, 0, 12'd4032, 1'b0, '0);
        probe(ACT_FILL, 32'sh0, 32'sh0040_0000, 32'sh0003_0000, 12'd0, 1'b0, '0);
        probe(ACT_FILL, 32'sh0, 32'shFFFF_FFFF, 32'shFFFD_0000, 12'd0, 1'b0, '0);
        probe(ACT_FILL, 32'sh0001_FFFF, 32'sh0000_8000, 32'sh0000_8000, 12'd0, 1'b0, '0);
        probe(ACT_READ, 0, 0, 0, 12'd4095, 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[k])
        begin
            send_item(probe_rows[k].act, probe_rows[k].xv, probe_rows[k].yv, probe_rows[k].w,
                      probe_rows[k].rb, probe_rows[k].typed, probe_rows[k].want);
        end

        // the default settings come last and are followed by a short extreme-weight run
        for (int k = 0; k < 8; k++)
        begin
            drain_results();
            apply_setup(plan_setup(k));
            run_random(ITEMS_PER_SETUP);
        end

        // back to back extreme weights into one bin, then the opposite sign into another
        idle_on = 1'b0;
        repeat (CLIP_FILLS)
        begin
            send_item(ACT_FILL, 32'sh000A_0000, 32'sh0014_0000, 32'sh7FFF_FFFF, 12'd0, 1'b0, '0);
        end
        repeat (CLIP_FILLS)
        begin
            send_item(ACT_FILL, 32'sh001E_0000, 32'sh0005_0000, 32'sh8000_0000, 12'd0, 1'b0, '0);
        end
        send_item(ACT_READ, 0, 0, 0, 12'd1290, 1'b0, '0);
        send_item(ACT_READ, 0, 0, 0, 12'd350, 1'b0, '0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d fills (%0d landed in a bin) and %0d reads over %0d register setups",
                 fills_sent, fills_landed, reads_sent, setups_applied);
        $display("summary: %0d results carried a clipped sum or total, %0d mismatches",
                 clips_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== weighted_2d_histogram_fill.f =====
rtl/core/wh2d_pkg.sv
rtl/core/wh2d_store.sv
rtl/core/weighted_2d_histogram_fill.sv
dv/testbench.sv
